@@ sv/dks_pkg.sv @@
// Shared constants, tables and permutation functions for the DES key schedule.
`default_nettype none

package dks_pkg;

  localparam int KEY_BITS    = 64;
  localparam int CD_BITS     = 56;
  localparam int HALF_BITS   = 28;
  localparam int SUBKEY_BITS = 48;
  localparam int ROUND_COUNT = 16;
  localparam int ROUND_W     = 4;
  localparam int SLOT_W      = 4;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_COUNT - 1);

  typedef logic [CD_BITS-1:0]     cd_t;
  typedef logic [HALF_BITS-1:0]   half_t;
  typedef logic [SUBKEY_BITS-1:0] subkey_t;

  // One subkey on its way to the result register
  typedef struct packed {
    subkey_t             subkey;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } result_t;

  // Key reduction table: 1-based key bit positions, first entry lands in the MSB
  localparam logic [6:0] PC1_TAB [CD_BITS] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  // Subkey selection table: 1-based positions within the 56-bit C:D word
  localparam logic [5:0] PC2_TAB [SUBKEY_BITS] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Rounds whose halves rotate by two places; the rest rotate by one
  localparam logic [ROUND_COUNT-1:0] ROT_TWO = 16'b0111_1110_1111_1100;

  function automatic cd_t pc1(input logic [KEY_BITS-1:0] key);
    cd_t        cd;
    logic [5:0] src;
    logic [5:0] dst;
    cd = '0;
    for (int i = 0; i < CD_BITS; i++) begin
      src = 6'(KEY_BITS - int'(PC1_TAB[i]));
      dst = 6'(CD_BITS - 1 - i);
      cd[dst] = key[src];
    end
    return cd;
  endfunction

  function automatic subkey_t pc2(input cd_t cd);
    subkey_t    sk;
    logic [5:0] src;
    logic [5:0] dst;
    sk = '0;
    for (int i = 0; i < SUBKEY_BITS; i++) begin
      src = 6'(CD_BITS - int'(PC2_TAB[i]));
      dst = 6'(SUBKEY_BITS - 1 - i);
      sk[dst] = cd[src];
    end
    return sk;
  endfunction

  function automatic half_t rot_half(input half_t h, input logic two);
    half_t r;
    if (two) begin
      r = {h[HALF_BITS-3:0], h[HALF_BITS-1:HALF_BITS-2]};
    end else begin
      r = {h[HALF_BITS-2:0], h[HALF_BITS-1]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/des_key_schedule.sv @@
// Top level of the DES key schedule: key register, round counter, result register.
//
// Usage:
//   Input: drive key_i and raise start; the key is taken at a rising edge with
//   start high and busy low. busy is high while the block still has rounds
//   of the current key to produce, and drops during the last round so the
//   next key can be taken without a gap.
//   Output: sixteen subkeys per key in round order, each on subkey_o, slot_o
//   and last_o for exactly one cycle with out_valid_o high; last_o marks
//   the sixteenth. The receiver cannot stall; results are never held.
//   Configuration: cfg_data_i is the decrypt-order bit, written when
//   cfg_valid_i is high (cfg_ready_o is always high). Write it while idle;
//   when set, slot_o counts 15 down to 0 instead of 0 up to 15.
//   Path: the accepted key is loaded into the C:D register, and each
//   round's subkey passes through the result register to the ports.
//   Throughput: one subkey per cycle, set by the single round unit
//   stepping the C:D register once per cycle.
//   Reset: asynchronous, active low; clears the run state, the result strobe
//   and the decrypt-order bit. No clearing pass is needed.
`default_nettype none

module des_key_schedule (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output      logic                               busy,
  input  wire logic [dks_pkg::KEY_BITS-1:0]       key_i,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic                               cfg_data_i,
  output      logic                               out_valid_o,
  output      logic [dks_pkg::SUBKEY_BITS-1:0]    subkey_o,
  output      logic [dks_pkg::SLOT_W-1:0]         slot_o,
  output      logic                               last_o
);

  dks_pkg::cd_t                  cd_q;
  dks_pkg::cd_t                  cd_d;
  dks_pkg::cd_t                  cd_pc1;
  dks_pkg::cd_t                  cd_rot;
  logic [dks_pkg::ROUND_W-1:0]   round_q;
  logic [dks_pkg::ROUND_W-1:0]   round_d;
  logic                          active_q;
  logic                          active_d;
  logic                          decrypt_q;
  logic                          valid_q;
  dks_pkg::result_t              res_q;
  dks_pkg::result_t              res_d;
  logic                          take;

  dks_pc1 u_pc1 (
    .key_i (key_i),
    .cd_o  (cd_pc1)
  );

  dks_round u_round (
    .cd_i      (cd_q),
    .round_i   (round_q),
    .decrypt_i (decrypt_q),
    .cd_o      (cd_rot),
    .res_o     (res_d)
  );

  // Accept a new item unless rounds other than the final one remain
  assign busy        = active_q && (round_q != dks_pkg::LAST_ROUND);
  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  // Load a fresh key, or advance the running one
  always_comb begin
    cd_d     = cd_q;
    round_d  = round_q;
    active_d = active_q;
    if (take) begin
      cd_d     = cd_pc1;
      round_d  = '0;
      active_d = 1'b1;
    end else if (active_q) begin
      cd_d     = cd_rot;
      round_d  = round_q + 1'b1;
      active_d = (round_q != dks_pkg::LAST_ROUND);
    end
  end

  // Hold run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_q  <= '0;
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      round_q  <= round_d;
      active_q <= active_d;
      valid_q  <= active_q;
    end
  end

  // Key word and result payload
  always_ff @(posedge clk_i) begin
    cd_q <= cd_d;
    if (active_q) begin
      res_q <= res_d;
    end
  end

  // Decrypt-order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decrypt_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      decrypt_q <= cfg_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign subkey_o    = res_q.subkey;
  assign slot_o      = res_q.slot;
  assign last_o      = res_q.last;

  // The last subkey of an item sits in the edge slot for the current order
  a_last_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      ((decrypt_q && slot_o == '0) ||
       (!decrypt_q && slot_o == dks_pkg::SLOT_W'(dks_pkg::LAST_ROUND))))
    else $error("last subkey carries the wrong slot");

  // Subkeys of one item come in an unbroken run
  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o)
    else $error("gap inside a run of subkeys");

  // An accepted item ends with its final subkey on the ports
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##17 (out_valid_o && last_o))
    else $error("final subkey not delivered on time");

  // Idle block never reports busy
  a_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> !busy)
    else $error("busy while idle");

endmodule

`default_nettype wire

@@ sv/dks_pc1.sv @@
// Key reduction: drop the parity bits and reorder the 64-bit key into the 56-bit C:D word.
`default_nettype none

module dks_pc1 (
  input  wire logic [dks_pkg::KEY_BITS-1:0] key_i,
  output dks_pkg::cd_t                      cd_o
);

  // Drop parity bits and reorder
  assign cd_o = dks_pkg::pc1(key_i);

endmodule

`default_nettype wire

@@ sv/dks_round.sv @@
// One key schedule round: rotate both halves, then pick the subkey bits from C:D.
`default_nettype none

module dks_round (
  input  wire dks_pkg::cd_t                    cd_i,
  input  wire logic [dks_pkg::ROUND_W-1:0]     round_i,
  input  wire logic                            decrypt_i,
  output dks_pkg::cd_t                         cd_o,
  output dks_pkg::result_t                     res_o
);

  dks_pkg::half_t c_rot;
  dks_pkg::half_t d_rot;
  logic           two;

  // Look up the shift for this round
  assign two = dks_pkg::ROT_TWO[round_i];

  // Rotate C and D left
  assign c_rot = dks_pkg::rot_half(cd_i[dks_pkg::CD_BITS-1:dks_pkg::HALF_BITS], two);
  assign d_rot = dks_pkg::rot_half(cd_i[dks_pkg::HALF_BITS-1:0], two);
  assign cd_o  = {c_rot, d_rot};

  // Select subkey, place it in its slot and mark the final round
  always_comb begin
    res_o.subkey = dks_pkg::pc2(cd_o);
    res_o.slot   = decrypt_i ? dks_pkg::SLOT_W'(dks_pkg::LAST_ROUND - round_i)
                             : dks_pkg::SLOT_W'(round_i);
    res_o.last   = (round_i == dks_pkg::LAST_ROUND);
  end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the DES key schedule: directed and random keys, both slot orders.
`timescale 1ns / 100ps

module testbench;

  localparam int KEY_W    = dks_pkg::KEY_BITS;
  localparam int SUB_W    = dks_pkg::SUBKEY_BITS;
  localparam int SLOT_BITS = dks_pkg::SLOT_W;
  localparam int ROUNDS   = dks_pkg::ROUND_COUNT;
  localparam int HALF_W   = 28;
  localparam int CD_W     = 56;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_KEYS   = 350;

  // Slot order values of the decrypt-order register
  localparam logic ORDER_ENCRYPT = 1'b0;
  localparam logic ORDER_DECRYPT = 1'b1;

  // Permuted choice 1: key bit numbers, bit 1 being the key MSB
  localparam int KEY_PICK [CD_W] = '{
    57, 49, 41, 33, 25, 17, 9,  1,  58, 50, 42, 34, 26, 18,
    10, 2,  59, 51, 43, 35, 27, 19, 11, 3,  60, 52, 44, 36,
    63, 55, 47, 39, 31, 23, 15, 7,  62, 54, 46, 38, 30, 22,
    14, 6,  61, 53, 45, 37, 29, 21, 13, 5,  28, 20, 12, 4
  };

  // Permuted choice 2: bit numbers within C:D, bit 1 being the MSB of C
  localparam int CD_PICK [SUB_W] = '{
    14, 17, 11, 24, 1,  5,  3,  28, 15, 6,  21, 10,
    23, 19, 12, 4,  26, 8,  16, 7,  27, 20, 13, 2,
    41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
    44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
  };

  // Left rotation of each half per round
  localparam int ROUND_SHIFT [ROUNDS] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

  typedef struct {
    logic [SUB_W-1:0]     subkey;
    logic [SLOT_BITS-1:0] slot;
    logic                 last;
  } subkey_rec_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [KEY_W-1:0]     key_i;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic                 cfg_data_i;
  logic                 out_valid_o;
  logic [SUB_W-1:0]     subkey_o;
  logic [SLOT_BITS-1:0] slot_o;
  logic                 last_o;

  subkey_rec_t expected_subkeys [$];
  logic        slot_order;
  bit          failed;
  int          calm_left;

  des_key_schedule dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .key_i       (key_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .subkey_o    (subkey_o),
    .slot_o      (slot_o),
    .last_o      (last_o)
  );

  always #2 clk_i = ~clk_i;

  // Run the sixteen rounds for one key and queue the subkeys they give
  function automatic void schedule_subkeys(input logic [KEY_W-1:0] key);
    logic [CD_W-1:0]   cd;
    logic [HALF_W-1:0] c_half;
    logic [HALF_W-1:0] d_half;
    subkey_rec_t       rec;
    for (int i = 0; i < CD_W; i++) begin
      cd[CD_W-1-i] = key[KEY_W-KEY_PICK[i]];
    end
    c_half = cd[CD_W-1:HALF_W];
    d_half = cd[HALF_W-1:0];
    for (int r = 0; r < ROUNDS; r++) begin
      for (int s = 0; s < ROUND_SHIFT[r]; s++) begin
        c_half = {c_half[HALF_W-2:0], c_half[HALF_W-1]};
        d_half = {d_half[HALF_W-2:0], d_half[HALF_W-1]};
      end
      cd = {c_half, d_half};
      for (int i = 0; i < SUB_W; i++) begin
        rec.subkey[SUB_W-1-i] = cd[CD_W-CD_PICK[i]];
      end
      rec.slot = (slot_order == ORDER_DECRYPT) ? SLOT_BITS'(ROUNDS - 1 - r) : SLOT_BITS'(r);
      rec.last = (r == ROUNDS - 1);
      expected_subkeys.push_back(rec);
    end
  endfunction

  // Draw the pause before the next key; now and then a calm stretch with none
  function automatic int idle_cycles();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm_left = $urandom_range(4, 16);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_key(input logic [KEY_W-1:0] key);
    int gap;
    gap = idle_cycles();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    key_i <= key;
    do @(posedge clk_i); while (busy);
    schedule_subkeys(key);
  endtask

  // Drop start and wait until every queued subkey has come out
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (expected_subkeys.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the decrypt-order register once the block is idle
  task automatic write_order(input logic order);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= order;
    do @(posedge clk_i); while (!cfg_ready_o);
    slot_order = order;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= $urandom_range(0, 1);
  endtask

  // Compare each subkey on the output with the oldest expectation
  always @(posedge clk_i) begin
    subkey_rec_t exp_rec;
    if (rst_ni && out_valid_o) begin
      if (expected_subkeys.size() == 0) begin
        $display("%0t: unexpected subkey %h slot %0d last %0b",
                 $time, subkey_o, slot_o, last_o);
        failed = 1'b1;
      end else begin
        exp_rec = expected_subkeys.pop_front();
        if (subkey_o !== exp_rec.subkey) begin
          $display("%0t: subkey expected %h actual %h", $time, exp_rec.subkey, subkey_o);
          failed = 1'b1;
        end
        if (slot_o !== exp_rec.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, exp_rec.slot, slot_o);
          failed = 1'b1;
        end
        if (last_o !== exp_rec.last) begin
          $display("%0t: last expected %0b actual %0b", $time, exp_rec.last, last_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Register left at reset value: slots must count upwards
  task automatic test_reset_order();
    send_key(64'h1334_5779_9BBC_DFF1);
    send_key(64'h0E32_9232_EA6D_0D73);
  endtask

  // Extreme and patterned keys, back to back where the gaps allow
  task automatic test_edge_keys();
    send_key('0);
    send_key('1);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h0000_0000_0000_0001);
    send_key(64'h0123_4567_89AB_CDEF);
  endtask

  // Parity bits only, all but the parity bits, and keys that differ from each other in parity alone
  task automatic test_parity_bits();
    logic [KEY_W-1:0] key;
    send_key(64'h0101_0101_0101_0101);
    send_key(64'hFEFE_FEFE_FEFE_FEFE);
    for (int i = 0; i < 3; i++) begin
      key = {$urandom, $urandom};
      send_key(key);
      send_key(key ^ ({$urandom, $urandom} & 64'h0101_0101_0101_0101));
    end
  endtask

  // Reversed slot order, then back again
  task automatic test_decrypt_order();
    write_order(ORDER_DECRYPT);
    send_key(64'h1334_5779_9BBC_DFF1);
    send_key('1);
    send_key('0);
    write_order(ORDER_ENCRYPT);
    send_key(64'h1334_5779_9BBC_DFF1);
  endtask

  // Random keys in phases, the register rewritten between phases
  task automatic test_random_keys();
    localparam int PHASES = 5;
    logic             order;
    logic [KEY_W-1:0] key;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: order = ORDER_DECRYPT;
        1: order = ORDER_DECRYPT;
        2: order = ORDER_ENCRYPT;
        default: order = $urandom_range(0, 1);
      endcase
      write_order(order);
      for (int i = 0; i < RANDOM_KEYS / PHASES; i++) begin
        key = {$urandom, $urandom};
        case ($urandom_range(0, 7))
          0: key = 64'h1 << $urandom_range(0, KEY_W - 1);
          1: key = ~(64'h1 << $urandom_range(0, KEY_W - 1));
          default: ;
        endcase
        send_key(key);
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    key_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    slot_order  = ORDER_ENCRYPT;
    failed      = 1'b0;
    calm_left   = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_order();
    test_edge_keys();
    test_parity_bits();
    test_decrypt_order();
    test_random_keys();
    wait_idle();

    if (failed) begin
      $display("TEST FAILED");
    end else begin
      $display("TEST PASSED");
    end
    $finish;
  end

  // Stop a run that hangs
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
